// File: rtl/core/rpt_pkg.sv
// Package: types, constants and state codes of the rendezvous pair table.
`default_nettype none
package rpt_pkg;

    localparam int ROOM_SLOTS = 128;
    localparam int SLOT_W     = $clog2(ROOM_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int EP_W       = 48;
    localparam int TS_W       = 32;
    localparam int KEY_W      = 64;
    localparam int SIDE_W     = EP_W + TS_W;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    localparam logic [1:0] ROLE_HOST   = 2'd0;
    localparam logic [1:0] ROLE_CLIENT = 2'd1;

    localparam logic KIND_WAIT = 1'b0;
    localparam logic KIND_PEER = 1'b1;

    typedef struct packed {
        logic [1:0]  role;
        logic [63:0] room_key;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [63:0] echo_key;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic used;
        logic host;
        logic client;
    } t_slot_flags;

    typedef struct packed {
        logic used_keep;
        logic host_keep;
        logic client_keep;
        logic key_hit;
    } t_slot_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RDEP,
        ST_PEER_H,
        ST_PEER_C,
        ST_WAIT_R
    } t_state;

endpackage
`default_nettype wire

// File: rtl/core/rpt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/rpt_age_unit.sv
// Shared per-slot unit: timeout aging of both marks and room key match.
`default_nettype none
module rpt_age_unit (
    input  wire logic [31:0]       i_now,
    input  wire logic [15:0]       i_timeout,
    input  wire logic [63:0]       i_key,
    input  wire rpt_pkg::t_slot_flags i_flags,
    input  wire logic [63:0]       i_slot_key,
    input  wire logic [31:0]       i_host_ts,
    input  wire logic [31:0]       i_client_ts,
    output rpt_pkg::t_slot_res     o_res
);

    logic [31:0] host_age;
    logic [31:0] client_age;
    logic        host_keep;
    logic        client_keep;

    always_comb begin
        host_age    = i_now - i_host_ts;
        client_age  = i_now - i_client_ts;
        host_keep   = i_flags.used && i_flags.host && !(host_age > {16'd0, i_timeout});
        client_keep = i_flags.used && i_flags.client && !(client_age > {16'd0, i_timeout});
        o_res.host_keep   = host_keep;
        o_res.client_keep = client_keep;
        o_res.used_keep   = host_keep || client_keep;
        o_res.key_hit     = (host_keep || client_keep) && (i_slot_key == i_key);
    end

endmodule
`default_nettype wire

// File: rtl/core/rendezvous_pair_table_unit.sv
// Top level: sequencer, slot flags and RAMs of the rendezvous pair table.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (timeout_seconds)
//
// The walk visits one slot per cycle through the aging/match unit and the RAM read port.
// Reset clears the slot flags at once; RAM contents need no clearing.
// The input is stalled from acceptance until the item's last result is loaded, or until
// the update step ends when the item gets no result.
`default_nettype none
module rendezvous_pair_table_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rpt_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rpt_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [15:0]       i_cfg_data
);

    localparam int N = rpt_pkg::ROOM_SLOTS;

    rpt_pkg::t_state    r_state, n_state;
    rpt_pkg::t_in_item  r_req;
    logic [15:0]        r_timeout;
    logic [N-1:0]       r_used, r_host, r_client;
    logic [rpt_pkg::CNT_W-1:0]  r_idx;
    logic                       r_ev_v;
    logic [rpt_pkg::SLOT_W-1:0] r_ev_idx;
    logic                       r_found_v, r_free_v;
    logic [rpt_pkg::SLOT_W-1:0] r_found, r_free, r_slot;
    logic                       r_out_v;
    rpt_pkg::t_out_item         r_out;

    logic                        accept;
    logic                        scan_more;
    logic                        scan_done;
    logic                        out_free;
    logic                        load_out;
    rpt_pkg::t_out_item          n_out;
    logic [rpt_pkg::SLOT_W-1:0]  sel_slot;
    logic                        host_after, client_after;
    logic                        rd_en;
    logic [rpt_pkg::SLOT_W-1:0]  rd_addr;
    logic                        we_key, we_host, we_client;
    logic [rpt_pkg::KEY_W-1:0]   key_q;
    logic [rpt_pkg::SIDE_W-1:0]  host_q, client_q;
    logic [rpt_pkg::SIDE_W-1:0]  side_wdata;
    rpt_pkg::t_slot_flags        ev_flags;
    rpt_pkg::t_slot_res          ev_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != rpt_pkg::ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign scan_more   = (r_idx < rpt_pkg::CNT_W'(N));
    assign scan_done   = r_ev_v && (r_ev_idx == rpt_pkg::SLOT_W'(N - 1));
    assign out_free    = !r_out_v || !i_out_stall;
    assign sel_slot    = r_found_v ? r_found : r_free;
    assign side_wdata  = {r_req.src_ip, r_req.src_port, r_req.now_seconds};

    always_comb begin
        ev_flags.used   = r_used[r_ev_idx];
        ev_flags.host   = r_host[r_ev_idx];
        ev_flags.client = r_client[r_ev_idx];
    end

    rpt_age_unit u_age (
        .i_now       (r_req.now_seconds),
        .i_timeout   (r_timeout),
        .i_key       (r_req.room_key),
        .i_flags     (ev_flags),
        .i_slot_key  (key_q),
        .i_host_ts   (host_q[rpt_pkg::TS_W-1:0]),
        .i_client_ts (client_q[rpt_pkg::TS_W-1:0]),
        .o_res       (ev_res)
    );

    rpt_ram #(.WIDTH(rpt_pkg::KEY_W), .DEPTH(N)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we_key),
        .i_waddr (sel_slot),
        .i_wdata (r_req.room_key),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (key_q)
    );

    rpt_ram #(.WIDTH(rpt_pkg::SIDE_W), .DEPTH(N)) u_host_ram (
        .i_clk   (i_clk),
        .i_we    (we_host),
        .i_waddr (sel_slot),
        .i_wdata (side_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (host_q)
    );

    rpt_ram #(.WIDTH(rpt_pkg::SIDE_W), .DEPTH(N)) u_client_ram (
        .i_clk   (i_clk),
        .i_we    (we_client),
        .i_waddr (sel_slot),
        .i_wdata (side_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (client_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = rpt_pkg::ST_SCAN;
                end
            end
            rpt_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = rpt_pkg::ST_UPDATE;
                end
            end
            rpt_pkg::ST_UPDATE: begin
                if (!r_found_v && !r_free_v) begin
                    n_state = rpt_pkg::ST_IDLE;
                end else if (r_req.role != rpt_pkg::ROLE_HOST &&
                             r_req.role != rpt_pkg::ROLE_CLIENT) begin
                    n_state = rpt_pkg::ST_IDLE;
                end else if (host_after && client_after) begin
                    n_state = rpt_pkg::ST_RDEP;
                end else begin
                    n_state = rpt_pkg::ST_WAIT_R;
                end
            end
            rpt_pkg::ST_RDEP: begin
                n_state = rpt_pkg::ST_PEER_H;
            end
            rpt_pkg::ST_PEER_H: begin
                if (out_free) begin
                    n_state = rpt_pkg::ST_PEER_C;
                end
            end
            rpt_pkg::ST_PEER_C: begin
                if (out_free) begin
                    n_state = rpt_pkg::ST_IDLE;
                end
            end
            rpt_pkg::ST_WAIT_R: begin
                if (out_free) begin
                    n_state = rpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        host_after   = (r_req.role == rpt_pkg::ROLE_HOST) || (r_found_v && r_host[sel_slot]);
        client_after = (r_req.role == rpt_pkg::ROLE_CLIENT) ||
                       (r_found_v && r_client[sel_slot]);
        rd_en     = 1'b0;
        rd_addr   = r_idx[rpt_pkg::SLOT_W-1:0];
        we_key    = 1'b0;
        we_host   = 1'b0;
        we_client = 1'b0;
        load_out  = 1'b0;
        n_out     = '0;
        case (r_state)
            rpt_pkg::ST_SCAN: begin
                rd_en = scan_more;
            end
            rpt_pkg::ST_UPDATE: begin
                we_key    = !r_found_v && r_free_v;
                we_host   = (r_found_v || r_free_v) && (r_req.role == rpt_pkg::ROLE_HOST);
                we_client = (r_found_v || r_free_v) && (r_req.role == rpt_pkg::ROLE_CLIENT);
            end
            rpt_pkg::ST_RDEP: begin
                rd_en   = 1'b1;
                rd_addr = r_slot;
            end
            rpt_pkg::ST_PEER_H: begin
                load_out        = out_free;
                n_out.kind      = rpt_pkg::KIND_PEER;
                n_out.dest_ip   = host_q[rpt_pkg::SIDE_W-1 -: 32];
                n_out.dest_port = host_q[rpt_pkg::TS_W +: 16];
                n_out.peer_ip   = client_q[rpt_pkg::SIDE_W-1 -: 32];
                n_out.peer_port = client_q[rpt_pkg::TS_W +: 16];
                n_out.last      = 1'b0;
            end
            rpt_pkg::ST_PEER_C: begin
                load_out        = out_free;
                n_out.kind      = rpt_pkg::KIND_PEER;
                n_out.dest_ip   = client_q[rpt_pkg::SIDE_W-1 -: 32];
                n_out.dest_port = client_q[rpt_pkg::TS_W +: 16];
                n_out.peer_ip   = host_q[rpt_pkg::SIDE_W-1 -: 32];
                n_out.peer_port = host_q[rpt_pkg::TS_W +: 16];
                n_out.last      = 1'b1;
            end
            rpt_pkg::ST_WAIT_R: begin
                load_out        = out_free;
                n_out.kind      = rpt_pkg::KIND_WAIT;
                n_out.dest_ip   = r_req.src_ip;
                n_out.dest_port = r_req.src_port;
                n_out.echo_key  = r_req.room_key;
                n_out.last      = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rpt_pkg::ST_IDLE;
            r_timeout <= rpt_pkg::TIMEOUT_RESET;
            r_used    <= '0;
            r_host    <= '0;
            r_client  <= '0;
            r_idx     <= '0;
            r_ev_v    <= 1'b0;
            r_found_v <= 1'b0;
            r_free_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                r_idx     <= '0;
                r_ev_v    <= 1'b0;
                r_found_v <= 1'b0;
                r_free_v  <= 1'b0;
            end
            if (r_state == rpt_pkg::ST_SCAN) begin
                if (scan_more) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_ev_v <= scan_more;
                if (r_ev_v) begin
                    r_used[r_ev_idx]   <= ev_res.used_keep;
                    r_host[r_ev_idx]   <= ev_res.host_keep;
                    r_client[r_ev_idx] <= ev_res.client_keep;
                    if (!r_found_v && ev_res.key_hit) begin
                        r_found_v <= 1'b1;
                    end
                    if (!r_free_v && !ev_res.used_keep) begin
                        r_free_v <= 1'b1;
                    end
                end
            end
            if (r_state == rpt_pkg::ST_UPDATE && (r_found_v || r_free_v)) begin
                if (!r_found_v) begin
                    r_used[sel_slot] <= 1'b1;
                end
                if (!r_found_v || r_req.role == rpt_pkg::ROLE_HOST) begin
                    r_host[sel_slot] <= (r_req.role == rpt_pkg::ROLE_HOST);
                end
                if (!r_found_v || r_req.role == rpt_pkg::ROLE_CLIENT) begin
                    r_client[sel_slot] <= (r_req.role == rpt_pkg::ROLE_CLIENT);
                end
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
        if (r_state == rpt_pkg::ST_SCAN) begin
            r_ev_idx <= r_idx[rpt_pkg::SLOT_W-1:0];
            if (r_ev_v && !r_found_v && ev_res.key_hit) begin
                r_found <= r_ev_idx;
            end
            if (r_ev_v && !r_free_v && !ev_res.used_keep) begin
                r_free <= r_ev_idx;
            end
        end
        if (r_state == rpt_pkg::ST_UPDATE) begin
            r_slot <= sel_slot;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire
